[hdl/obbsat_pkg.sv]
// shared types, widths and helpers for the oriented box separating axis test
`default_nettype none
package obbsat_pkg;

    localparam int COMP_W   = 16;   // packed q8.8 component
    localparam int VEC_W    = 48;   // three packed components
    localparam int DIFF_W   = 17;   // centre difference component
    localparam int AXIS_W   = 33;   // test axis component, q16.16
    localparam int NUM_AXES = 15;
    localparam int NUM_BOX  = 6;    // box a axes then box b axes
    localparam int PROD_W   = 49;   // axis component times box component
    localparam int DOT_W    = 51;   // sum of three products
    localparam int TERM_W   = 67;   // dot magnitude times half extent
    localparam int RAD_W    = 70;   // sum of six terms
    localparam int CPROD_W  = 50;   // difference component times axis component
    localparam int CDOT_W   = 52;   // centre projection
    localparam int CPROJ_W  = 60;   // centre projection in q32.32

    typedef logic signed [COMP_W-1:0] t_comp;
    typedef t_comp t_vec [3];
    typedef logic signed [AXIS_W-1:0] t_acomp;
    typedef t_acomp t_axis [3];
    typedef logic signed [DIFF_W-1:0] t_dcomp;
    typedef t_dcomp t_diff [3];
    typedef logic [COMP_W-1:0] t_half;

    function automatic t_vec unpack_vec(input logic [VEC_W-1:0] p);
        t_vec v;
        for (int k = 0; k < 3; k++) begin
            v[k] = $signed(p[k*COMP_W +: COMP_W]);
        end
        return v;
    endfunction

endpackage
`default_nettype wire

[hdl/obbsat_front.sv]
// input stage: unpacking, centre difference, face axes and cross product axes
`default_nettype none
module obbsat_front (
    input  wire logic                           i_clk,
    input  wire logic                           i_en,
    input  wire logic [obbsat_pkg::VEC_W-1:0]   i_centre_a,
    input  wire logic [obbsat_pkg::VEC_W-1:0]   i_centre_b,
    input  wire logic [obbsat_pkg::VEC_W-1:0]   i_a_axis_x,
    input  wire logic [obbsat_pkg::VEC_W-1:0]   i_a_axis_y,
    input  wire logic [obbsat_pkg::VEC_W-1:0]   i_a_axis_z,
    input  wire logic [obbsat_pkg::VEC_W-1:0]   i_b_axis_x,
    input  wire logic [obbsat_pkg::VEC_W-1:0]   i_b_axis_y,
    input  wire logic [obbsat_pkg::VEC_W-1:0]   i_b_axis_z,
    input  wire logic [obbsat_pkg::VEC_W-1:0]   i_half_extents_a,
    input  wire logic [obbsat_pkg::VEC_W-1:0]   i_half_extents_b,
    output obbsat_pkg::t_axis                   o_axes [obbsat_pkg::NUM_AXES],
    output obbsat_pkg::t_diff                   o_diff,
    output obbsat_pkg::t_vec                    o_box [obbsat_pkg::NUM_BOX],
    output obbsat_pkg::t_half                   o_half [obbsat_pkg::NUM_BOX]
);

    function automatic obbsat_pkg::t_acomp cross_comp(
        input obbsat_pkg::t_comp a, input obbsat_pkg::t_comp b,
        input obbsat_pkg::t_comp c, input obbsat_pkg::t_comp d);
        logic signed [2*obbsat_pkg::COMP_W-1:0] m1;
        logic signed [2*obbsat_pkg::COMP_W-1:0] m2;
        m1 = a * b;
        m2 = c * d;
        return obbsat_pkg::AXIS_W'(m1) - obbsat_pkg::AXIS_W'(m2);
    endfunction

    obbsat_pkg::t_vec  ca, cb, ha, hb;
    obbsat_pkg::t_vec  n_box [obbsat_pkg::NUM_BOX];
    obbsat_pkg::t_axis n_axes [obbsat_pkg::NUM_AXES];
    obbsat_pkg::t_diff n_diff;
    obbsat_pkg::t_half n_half [obbsat_pkg::NUM_BOX];

    obbsat_pkg::t_axis r_axes [obbsat_pkg::NUM_AXES];
    obbsat_pkg::t_diff r_diff;
    obbsat_pkg::t_vec  r_box [obbsat_pkg::NUM_BOX];
    obbsat_pkg::t_half r_half [obbsat_pkg::NUM_BOX];

    always_comb begin
        ca       = obbsat_pkg::unpack_vec(i_centre_a);
        cb       = obbsat_pkg::unpack_vec(i_centre_b);
        ha       = obbsat_pkg::unpack_vec(i_half_extents_a);
        hb       = obbsat_pkg::unpack_vec(i_half_extents_b);
        n_box[0] = obbsat_pkg::unpack_vec(i_a_axis_x);
        n_box[1] = obbsat_pkg::unpack_vec(i_a_axis_y);
        n_box[2] = obbsat_pkg::unpack_vec(i_a_axis_z);
        n_box[3] = obbsat_pkg::unpack_vec(i_b_axis_x);
        n_box[4] = obbsat_pkg::unpack_vec(i_b_axis_y);
        n_box[5] = obbsat_pkg::unpack_vec(i_b_axis_z);
        for (int k = 0; k < 3; k++) begin
            n_diff[k]   = obbsat_pkg::DIFF_W'(cb[k]) - obbsat_pkg::DIFF_W'(ca[k]);
            // half extents count by magnitude only
            n_half[k]   = ha[k][obbsat_pkg::COMP_W-1] ? obbsat_pkg::t_half'(-ha[k])
                                                      : obbsat_pkg::t_half'(ha[k]);
            n_half[k+3] = hb[k][obbsat_pkg::COMP_W-1] ? obbsat_pkg::t_half'(-hb[k])
                                                      : obbsat_pkg::t_half'(hb[k]);
        end
        // face axes widened from q8.8 to q16.16
        for (int b = 0; b < obbsat_pkg::NUM_BOX; b++) begin
            for (int k = 0; k < 3; k++) begin
                n_axes[b][k] = $signed({{(obbsat_pkg::AXIS_W-obbsat_pkg::COMP_W-8)
                                         {n_box[b][k][obbsat_pkg::COMP_W-1]}},
                                        n_box[b][k], 8'b0});
            end
        end
        // edge axes: a axis i cross b axis j
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                n_axes[6+3*i+j][0] = cross_comp(n_box[i][1], n_box[3+j][2],
                                                n_box[i][2], n_box[3+j][1]);
                n_axes[6+3*i+j][1] = cross_comp(n_box[i][2], n_box[3+j][0],
                                                n_box[i][0], n_box[3+j][2]);
                n_axes[6+3*i+j][2] = cross_comp(n_box[i][0], n_box[3+j][1],
                                                n_box[i][1], n_box[3+j][0]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_axes <= n_axes;
            r_diff <= n_diff;
            r_box  <= n_box;
            r_half <= n_half;
        end
    end

    assign o_axes = r_axes;
    assign o_diff = r_diff;
    assign o_box  = r_box;
    assign o_half = r_half;

endmodule
`default_nettype wire

[hdl/obbsat_lane.sv]
// one candidate axis: projections, radius sum and separation compare over four stages
`default_nettype none
module obbsat_lane (
    input  wire logic                i_clk,
    input  wire logic                i_en,
    input  obbsat_pkg::t_axis        i_axis,
    input  obbsat_pkg::t_diff        i_diff,
    input  obbsat_pkg::t_vec         i_box [obbsat_pkg::NUM_BOX],
    input  obbsat_pkg::t_half        i_half [obbsat_pkg::NUM_BOX],  // lines up with the registered dot magnitudes
    output logic                     o_pass
);

    typedef logic signed [obbsat_pkg::PROD_W-1:0]  t_prod;
    typedef logic signed [obbsat_pkg::CPROD_W-1:0] t_cprod;

    t_prod                               n_prod [obbsat_pkg::NUM_BOX][3];
    t_cprod                              n_cprod [3];
    logic [obbsat_pkg::DOT_W-1:0]        n_dmag [obbsat_pkg::NUM_BOX];
    logic [obbsat_pkg::CDOT_W-1:0]       n_cmag;
    logic [obbsat_pkg::TERM_W-1:0]       n_term [obbsat_pkg::NUM_BOX];
    logic                                n_pass;

    t_prod                               r_prod [obbsat_pkg::NUM_BOX][3];
    t_cprod                              r_cprod [3];
    logic [obbsat_pkg::DOT_W-1:0]        r_dmag [obbsat_pkg::NUM_BOX];
    logic [obbsat_pkg::CDOT_W-1:0]       r_cmag;
    logic [obbsat_pkg::TERM_W-1:0]       r_term [obbsat_pkg::NUM_BOX];
    logic [obbsat_pkg::CDOT_W-1:0]       r_cmag_d;
    logic                                r_pass;

    // products
    always_comb begin
        for (int b = 0; b < obbsat_pkg::NUM_BOX; b++) begin
            for (int k = 0; k < 3; k++) begin
                n_prod[b][k] = i_axis[k] * i_box[b][k];
            end
        end
        for (int k = 0; k < 3; k++) begin
            n_cprod[k] = i_diff[k] * i_axis[k];
        end
    end

    // dot sums and magnitudes
    always_comb begin
        logic signed [obbsat_pkg::DOT_W-1:0]  s;
        logic signed [obbsat_pkg::CDOT_W-1:0] c;
        for (int b = 0; b < obbsat_pkg::NUM_BOX; b++) begin
            s = obbsat_pkg::DOT_W'(r_prod[b][0]) + obbsat_pkg::DOT_W'(r_prod[b][1])
              + obbsat_pkg::DOT_W'(r_prod[b][2]);
            n_dmag[b] = s[obbsat_pkg::DOT_W-1] ? obbsat_pkg::DOT_W'(-s)
                                               : obbsat_pkg::DOT_W'(s);
        end
        c = obbsat_pkg::CDOT_W'(r_cprod[0]) + obbsat_pkg::CDOT_W'(r_cprod[1])
          + obbsat_pkg::CDOT_W'(r_cprod[2]);
        n_cmag = c[obbsat_pkg::CDOT_W-1] ? obbsat_pkg::CDOT_W'(-c) : obbsat_pkg::CDOT_W'(c);
    end

    // scale by half extents
    always_comb begin
        for (int b = 0; b < obbsat_pkg::NUM_BOX; b++) begin
            n_term[b] = obbsat_pkg::TERM_W'(r_dmag[b]) * obbsat_pkg::TERM_W'(i_half[b]);
        end
    end

    // radius sum against centre projection, touching counts as overlap
    always_comb begin
        logic [obbsat_pkg::RAD_W-1:0] rad;
        rad = '0;
        for (int b = 0; b < obbsat_pkg::NUM_BOX; b++) begin
            rad = rad + obbsat_pkg::RAD_W'(r_term[b]);
        end
        n_pass = rad >= obbsat_pkg::RAD_W'({r_cmag_d, 8'b0});
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod   <= n_prod;
            r_cprod  <= n_cprod;
            r_dmag   <= n_dmag;
            r_cmag   <= n_cmag;
            r_term   <= n_term;
            r_cmag_d <= r_cmag;
            r_pass   <= n_pass;
        end
    end

    assign o_pass = r_pass;

endmodule
`default_nettype wire

[hdl/obb_separating_axis_test.sv]
// top level of the oriented box overlap test over fifteen candidate axes
// throughput: one word per cycle while the output is not stalled; all fifteen axis lanes run in parallel
// a stalled output freezes the whole pipeline, nothing is dropped or repeated
// reset (synchronous, active low) clears only the valid bits; data regs are not reset
`default_nettype none
module obb_separating_axis_test (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_stall,
    input  wire logic [obbsat_pkg::VEC_W-1:0]   i_centre_a,
    input  wire logic [obbsat_pkg::VEC_W-1:0]   i_centre_b,
    input  wire logic [obbsat_pkg::VEC_W-1:0]   i_a_axis_x,
    input  wire logic [obbsat_pkg::VEC_W-1:0]   i_a_axis_y,
    input  wire logic [obbsat_pkg::VEC_W-1:0]   i_a_axis_z,
    input  wire logic [obbsat_pkg::VEC_W-1:0]   i_b_axis_x,
    input  wire logic [obbsat_pkg::VEC_W-1:0]   i_b_axis_y,
    input  wire logic [obbsat_pkg::VEC_W-1:0]   i_b_axis_z,
    input  wire logic [obbsat_pkg::VEC_W-1:0]   i_half_extents_a,
    input  wire logic [obbsat_pkg::VEC_W-1:0]   i_half_extents_b,
    output logic                                o_valid,
    input  wire logic                           i_stall,
    output logic                                o_overlap
);

    localparam int DEPTH = 6;

    // stage valid bits, one per pipeline stage
    logic [DEPTH-1:0]                 r_vld;
    logic                             en;
    logic                             r_overlap;

    obbsat_pkg::t_axis                axes [obbsat_pkg::NUM_AXES];
    obbsat_pkg::t_diff                diff;
    obbsat_pkg::t_vec                 box [obbsat_pkg::NUM_BOX];
    obbsat_pkg::t_half                half [obbsat_pkg::NUM_BOX];
    // half extents delayed to line up with the lane scaling stage
    obbsat_pkg::t_half                r_half_s2 [obbsat_pkg::NUM_BOX];
    obbsat_pkg::t_half                r_half_s3 [obbsat_pkg::NUM_BOX];
    logic [obbsat_pkg::NUM_AXES-1:0]  pass;

    // stall only when the output word is held
    assign o_stall = r_vld[DEPTH-1] && i_stall;
    assign en      = !o_stall;

    // stage 1: unpack, centre difference, build the fifteen axes
    obbsat_front u_front (
        .i_clk            (i_clk),
        .i_en             (en),
        .i_centre_a       (i_centre_a),
        .i_centre_b       (i_centre_b),
        .i_a_axis_x       (i_a_axis_x),
        .i_a_axis_y       (i_a_axis_y),
        .i_a_axis_z       (i_a_axis_z),
        .i_b_axis_x       (i_b_axis_x),
        .i_b_axis_y       (i_b_axis_y),
        .i_b_axis_z       (i_b_axis_z),
        .i_half_extents_a (i_half_extents_a),
        .i_half_extents_b (i_half_extents_b),
        .o_axes           (axes),
        .o_diff           (diff),
        .o_box            (box),
        .o_half           (half)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_half_s2 <= half;
            r_half_s3 <= r_half_s2;
        end
    end

    // stages 2 to 5: one lane per candidate axis
    for (genvar g = 0; g < obbsat_pkg::NUM_AXES; g++) begin : g_lane
        obbsat_lane u_lane (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_axis (axes[g]),
            .i_diff (diff),
            .i_box  (box),
            .i_half (r_half_s3),
            .o_pass (pass[g])
        );
    end

    // stage 6: overlap only when no axis separates
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_overlap <= &pass;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[DEPTH-2:0], i_valid};
        end
    end

    assign o_valid   = r_vld[DEPTH-1];
    assign o_overlap = r_overlap;

    a_stall_needs_word: assert property (@(posedge i_clk) o_stall |-> o_valid)
        else $error("stall raised with no output word");
    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |=> $stable(r_vld))
        else $error("pipeline moved while stalled");
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> r_vld[0])
        else $error("accepted word not tracked in first stage");
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule
`default_nettype wire

[bench/tb_top.sv]
// testbench for the oriented box separating axis overlap test
`timescale 1ns / 1ps
`default_nettype none
module tb_top;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 20;

    // one box pair as driven on the input ports
    typedef struct packed {
        logic [obbsat_pkg::VEC_W-1:0] centre_a;
        logic [obbsat_pkg::VEC_W-1:0] centre_b;
        logic [obbsat_pkg::VEC_W-1:0] a_ax;
        logic [obbsat_pkg::VEC_W-1:0] a_ay;
        logic [obbsat_pkg::VEC_W-1:0] a_az;
        logic [obbsat_pkg::VEC_W-1:0] b_ax;
        logic [obbsat_pkg::VEC_W-1:0] b_ay;
        logic [obbsat_pkg::VEC_W-1:0] b_az;
        logic [obbsat_pkg::VEC_W-1:0] half_a;
        logic [obbsat_pkg::VEC_W-1:0] half_b;
    } t_box_pair;

    // marker that makes the driver hold off until all results are back
    typedef struct {
        t_box_pair pair;
        bit        drain_first;
    } t_pending;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_valid = 1'b0;
    logic             i_stall = 1'b0;
    logic [obbsat_pkg::VEC_W-1:0] i_centre_a = '0, i_centre_b = '0;
    logic [obbsat_pkg::VEC_W-1:0] i_a_axis_x = '0, i_a_axis_y = '0, i_a_axis_z = '0;
    logic [obbsat_pkg::VEC_W-1:0] i_b_axis_x = '0, i_b_axis_y = '0, i_b_axis_z = '0;
    logic [obbsat_pkg::VEC_W-1:0] i_half_extents_a = '0, i_half_extents_b = '0;
    logic             o_stall, o_valid, o_overlap;

    t_pending pending_pairs [$];
    bit       expected_overlap [$];
    int       error_count = 0;
    bit       stimulus_done = 1'b0;

    obb_separating_axis_test dut (
        .i_clk, .i_rst_n, .i_valid, .o_stall,
        .i_centre_a, .i_centre_b,
        .i_a_axis_x, .i_a_axis_y, .i_a_axis_z,
        .i_b_axis_x, .i_b_axis_y, .i_b_axis_z,
        .i_half_extents_a, .i_half_extents_b,
        .o_valid, .i_stall, .o_overlap
    );

    always #5 i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // overlap predictor, exact wide integer arithmetic
    // ---------------------------------------------------------------
    typedef logic signed [127:0] t_big;
    typedef t_big t_vec_big [3];

    function automatic t_vec_big split_vec(input logic [obbsat_pkg::VEC_W-1:0] p);
        t_vec_big v;
        for (int k = 0; k < 3; k++) v[k] = t_big'($signed(p[k*16 +: 16]));
        return v;
    endfunction

    function automatic t_big dot_big(input t_vec_big p, input t_vec_big q);
        return p[0]*q[0] + p[1]*q[1] + p[2]*q[2];
    endfunction

    function automatic t_big abs_big(input t_big v);
        return v < 0 ? -v : v;
    endfunction

    // true when axis l does not separate the boxes (touching is overlap)
    function automatic bit axis_holds(input t_vec_big l, input t_vec_big diff,
                                      input t_vec_big ax [6], input t_vec_big ha,
                                      input t_vec_big hb);
        t_big radius, centre_proj;
        radius = 0;
        for (int k = 0; k < 3; k++) begin
            radius += abs_big(dot_big(l, ax[k])) * abs_big(ha[k]);
            radius += abs_big(dot_big(l, ax[3+k])) * abs_big(hb[k]);
        end
        centre_proj = abs_big(dot_big(diff, l)) * 256;
        return centre_proj <= radius;
    endfunction

    function automatic bit predict_overlap(input t_box_pair bp);
        t_vec_big ax [6];
        t_vec_big ca, cb, diff, ha, hb, l;
        bit all_hold;
        all_hold = 1'b1;
        ca = split_vec(bp.centre_a);
        cb = split_vec(bp.centre_b);
        ha = split_vec(bp.half_a);
        hb = split_vec(bp.half_b);
        ax[0] = split_vec(bp.a_ax); ax[1] = split_vec(bp.a_ay);
        ax[2] = split_vec(bp.a_az); ax[3] = split_vec(bp.b_ax);
        ax[4] = split_vec(bp.b_ay); ax[5] = split_vec(bp.b_az);
        for (int k = 0; k < 3; k++) diff[k] = cb[k] - ca[k];
        // face axes, widened to q16.16
        for (int i = 0; i < 6; i++) begin
            for (int k = 0; k < 3; k++) l[k] = ax[i][k] * 256;
            if (!axis_holds(l, diff, ax, ha, hb)) all_hold = 1'b0;
        end
        // edge cross products; a zero product always holds
        for (int i = 0; i < 3; i++) begin
            for (int j = 3; j < 6; j++) begin
                l[0] = ax[i][1]*ax[j][2] - ax[i][2]*ax[j][1];
                l[1] = ax[i][2]*ax[j][0] - ax[i][0]*ax[j][2];
                l[2] = ax[i][0]*ax[j][1] - ax[i][1]*ax[j][0];
                if (!axis_holds(l, diff, ax, ha, hb)) all_hold = 1'b0;
            end
        end
        return all_hold;
    endfunction

    // ---------------------------------------------------------------
    // stimulus generation
    // ---------------------------------------------------------------
    function automatic logic [15:0] rand_comp(input int span);
        int r;
        r = $urandom_range(7);
        if (r == 0) return 16'($urandom);
        if (r == 1) begin
            case ($urandom_range(4))
                0: return 16'h7fff;
                1: return 16'h8000;
                2: return 16'hffff;
                3: return 16'h0000;
                default: return 16'h0100;
            endcase
        end
        return 16'($signed($urandom_range(2*span)) - span);
    endfunction

    function automatic logic [obbsat_pkg::VEC_W-1:0] rand_vec(input int span);
        return {rand_comp(span), rand_comp(span), rand_comp(span)};
    endfunction

    function automatic logic [obbsat_pkg::VEC_W-1:0] mk_vec(input int x, input int y,
                                                            input int z);
        return {16'(z), 16'(y), 16'(x)};
    endfunction

    // random axis frames with boxes placed near each other
    function automatic t_box_pair near_pair();
        t_box_pair bp;
        int span;
        span = ($urandom_range(3) == 0) ? 2048 : 512;
        bp.centre_a = rand_vec(span);
        bp.centre_b = ($urandom_range(1)) ? rand_vec(span)
                    : bp.centre_a ^ {3{16'($urandom_range(255))}};
        bp.a_ax = rand_vec(300); bp.a_ay = rand_vec(300); bp.a_az = rand_vec(300);
        bp.b_ax = rand_vec(300); bp.b_ay = rand_vec(300); bp.b_az = rand_vec(300);
        bp.half_a = rand_vec(span);
        bp.half_b = rand_vec(span);
        return bp;
    endfunction

    function automatic t_box_pair noise_pair();
        t_box_pair bp;
        bp = {$urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom, $urandom, $urandom, $urandom, $urandom};
        return bp;
    endfunction

    task automatic push_pair(input t_box_pair bp, input bit drain_first);
        t_pending p;
        p.pair = bp;
        p.drain_first = drain_first;
        pending_pairs.insert(pending_pairs.size(), p);
    endtask

    initial begin
        t_box_pair bp;
        logic [obbsat_pkg::VEC_W-1:0] ux, uy, uz;
        ux = mk_vec(256, 0, 0); uy = mk_vec(0, 256, 0); uz = mk_vec(0, 0, 256);
        // identical aligned unit boxes at the same spot
        bp = '{mk_vec(0,0,0), mk_vec(0,0,0), ux, uy, uz, ux, uy, uz,
               mk_vec(256,256,256), mk_vec(256,256,256)};
        push_pair(bp, 0);
        // exactly touching on x
        bp.centre_b = mk_vec(512, 0, 0);
        push_pair(bp, 0);
        // one step apart, separated on x
        bp.centre_b = mk_vec(513, 0, 0);
        push_pair(bp, 0);
        // negative half extents act by magnitude
        bp.half_a = mk_vec(-256, -256, -256);
        bp.centre_b = mk_vec(512, 0, 0);
        push_pair(bp, 0);
        // parallel axes give zero cross products
        bp.half_a = mk_vec(256, 256, 256);
        bp.b_ax = mk_vec(512, 0, 0);
        push_pair(bp, 0);
        // all zero axes and extents, centres apart
        bp = '{mk_vec(0,0,0), mk_vec(1,0,0), '0, '0, '0, '0, '0, '0, '0, '0};
        push_pair(bp, 0);
        // rotated frame, non unit and non orthogonal axes
        bp = '{mk_vec(0,0,0), mk_vec(300,300,0), mk_vec(181,181,0),
               mk_vec(-181,181,0), uz, mk_vec(300,10,0), mk_vec(5,200,7),
               mk_vec(1,2,400), mk_vec(128,128,128), mk_vec(100,50,25)};
        push_pair(bp, 0);
        // field extremes
        bp = {10{mk_vec(32767, 32767, 32767)}};
        push_pair(bp, 0);
        bp = {10{mk_vec(-32768, -32768, -32768)}};
        push_pair(bp, 0);
        bp.centre_a = mk_vec(32767, 32767, 32767);
        push_pair(bp, 0);
        bp = '{mk_vec(-32768,-32768,-32768), mk_vec(32767,32767,32767),
               mk_vec(-32768,32767,0), mk_vec(32767,-32768,1),
               mk_vec(0,-32768,32767), mk_vec(32767,0,-32768),
               mk_vec(-32768,-32768,32767), mk_vec(1,-1,-32768),
               mk_vec(-32768,32767,-32768), mk_vec(32767,-32768,32767)};
        push_pair(bp, 0);
        push_pair('0, 0);
        push_pair('1, 0);
        // random part, mostly plausible geometry, some raw noise
        for (int n = 0; n < 1400; n++) begin
            if ($urandom_range(4) == 0) bp = noise_pair();
            else bp = near_pair();
            push_pair(bp, (n % 350) == 175);
        end
        stimulus_done = 1'b1;
    end

    // ---------------------------------------------------------------
    // driver
    // ---------------------------------------------------------------
    int send_gap = 0;
    always @(posedge i_clk) begin
        t_pending p;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || !o_stall) begin
            // previous word taken or none shown
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                i_valid <= 1'b0;
            end else if (pending_pairs.size() > 0 &&
                         !(pending_pairs[0].drain_first &&
                           (i_valid || expected_overlap.size() > 0))) begin
                p = pending_pairs.pop_front();
                i_centre_a <= p.pair.centre_a;
                i_centre_b <= p.pair.centre_b;
                i_a_axis_x <= p.pair.a_ax;
                i_a_axis_y <= p.pair.a_ay;
                i_a_axis_z <= p.pair.a_az;
                i_b_axis_x <= p.pair.b_ax;
                i_b_axis_y <= p.pair.b_ay;
                i_b_axis_z <= p.pair.b_az;
                i_half_extents_a <= p.pair.half_a;
                i_half_extents_b <= p.pair.half_b;
                i_valid <= 1'b1;
                // long stretches without gaps now and then
                send_gap <= ($urandom_range(3) == 0) ? 0 : $urandom_range(19);
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // expectation recorded at the accepting edge
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall) begin
            expected_overlap.insert(expected_overlap.size(),
                predict_overlap({i_centre_a, i_centre_b,
                i_a_axis_x, i_a_axis_y, i_a_axis_z, i_b_axis_x, i_b_axis_y,
                i_b_axis_z, i_half_extents_a, i_half_extents_b}));
        end
    end

    // ---------------------------------------------------------------
    // monitor and receiver stall
    // ---------------------------------------------------------------
    int stall_left = 0;
    always @(posedge i_clk) begin
        bit want;
        int gap;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (expected_overlap.size() == 0) begin
                    $display("%0t: unexpected result word, expected none, actual overlap=%0b",
                             $time, o_overlap);
                    error_count++;
                end else begin
                    want = expected_overlap.pop_front();
                    if (o_overlap !== want) begin
                        $display("%0t: overlap mismatch, expected %0b, actual %0b",
                                 $time, want, o_overlap);
                        error_count++;
                    end
                end
                gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(19);
                stall_left <= (gap > 0) ? gap - 1 : 0;
                i_stall <= (gap > 0);
            end else if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // reset, watchdog and end of run
    // ---------------------------------------------------------------
    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (stimulus_done && pending_pairs.size() == 0);
        @(posedge i_clk);
        while (i_valid || expected_overlap.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0 && expected_overlap.size() == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
`default_nettype wire
